// File: hdl/cpos_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpos_pkg
// Shared widths, types and region codes for the segment nearest-point block.
// ----------------------------------------------------------------------------
package cpos_pkg;

  localparam int CW        = 16;            // coordinate bits
  localparam int FW        = 16;            // fraction bits
  localparam int DW        = CW + 1;        // difference bits
  localparam int PW        = 2 * DW;        // product bits
  localparam int NW        = PW + 2;        // sum of three products
  localparam int NS        = FW + 1;        // division steps
  localparam int MW        = DW + FW + 2;   // near-point product bits
  localparam int MID_DEPTH = 8;
  localparam int OUT_DEPTH = 32;
  localparam int MID_AW    = $clog2(MID_DEPTH);
  localparam int OUT_AW    = $clog2(OUT_DEPTH);
  localparam int MID_CW    = $clog2(MID_DEPTH + 1);
  localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

  typedef enum logic [1:0] {
    REG_BEFORE = 2'd0,
    REG_BEYOND = 2'd1,
    REG_INSIDE = 2'd2
  } region_e;

  typedef logic [2:0][CW-1:0] cvec_t;
  typedef logic [2:0][DW-1:0] dvec_t;

  typedef struct packed {
    region_e         region;
    logic [PW-1:0]   num;
    logic [PW-1:0]   den;
    cvec_t           s;
    cvec_t           t;
    dvec_t           d;
  } cls_t;

  typedef struct packed {
    region_e         region;
    logic [FW:0]     frac;
    cvec_t           near;
  } res_t;

endpackage

// File: hdl/cpos_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpos_front
// Three-stage front: differences, products, sums and region classification.
// ----------------------------------------------------------------------------
module cpos_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  cpos_pkg::cvec_t start_i,
  input  cpos_pkg::cvec_t end_i,
  input  cpos_pkg::cvec_t query_i,
  output logic           cls_valid_o,
  output cpos_pkg::cls_t cls_o
);
  import cpos_pkg::*;

  logic v1_q, v2_q, v3_q;
  cvec_t s1_q, t1_q, s2_q, t2_q;
  logic signed [DW-1:0] d1_q [3];
  logic signed [DW-1:0] e1_q [3];
  logic signed [DW-1:0] d2_q [3];
  logic signed [PW-1:0] ne_q [3];
  logic signed [PW-1:0] dd_q [3];
  cls_t cls_q, cls_d;
  logic signed [NW-1:0] num_s, den_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= start_i;
    t1_q <= end_i;
    s2_q <= s1_q;
    t2_q <= t1_q;
    for (int i = 0; i < 3; i++) begin
      d1_q[i] <= $signed({end_i[i][CW-1], end_i[i]}) -
                 $signed({start_i[i][CW-1], start_i[i]});
      e1_q[i] <= $signed({query_i[i][CW-1], query_i[i]}) -
                 $signed({start_i[i][CW-1], start_i[i]});
      d2_q[i] <= d1_q[i];
      ne_q[i] <= PW'(d1_q[i]) * PW'(e1_q[i]);
      dd_q[i] <= PW'(d1_q[i]) * PW'(d1_q[i]);
    end
    cls_q <= cls_d;
  end

  always_comb begin
    num_s = NW'(ne_q[0]) + NW'(ne_q[1]) + NW'(ne_q[2]);
    den_s = NW'(dd_q[0]) + NW'(dd_q[1]) + NW'(dd_q[2]);
    cls_d.num = num_s[PW-1:0];
    cls_d.den = den_s[PW-1:0];
    cls_d.s   = s2_q;
    cls_d.t   = t2_q;
    for (int i = 0; i < 3; i++) begin
      cls_d.d[i] = d2_q[i];
    end
    if (den_s == '0 || num_s <= NW'(0)) begin
      cls_d.region = REG_BEFORE;
    end else if (num_s >= den_s) begin
      cls_d.region = REG_BEYOND;
    end else begin
      cls_d.region = REG_INSIDE;
    end
  end

  assign cls_valid_o = v3_q;
  assign cls_o       = cls_q;

endmodule

// File: hdl/cpos_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpos_queue
// Short queue of classified requests between the front and the back.
// ----------------------------------------------------------------------------
module cpos_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  cpos_pkg::cls_t wr_data_i,
  input  logic           rd_i,
  output logic           empty_o,
  output cpos_pkg::cls_t rd_data_o
);
  import cpos_pkg::*;

  cls_t mem_q [MID_DEPTH];
  logic [MID_AW-1:0] wp_q, rp_q;
  logic [MID_CW-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_i) wp_q <= wp_q + 1'b1;
      if (rd_i) rp_q <= rp_q + 1'b1;
      if (wr_i && !rd_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!wr_i && rd_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wp_q] <= wr_data_i;
  end

  assign empty_o   = (cnt_q == '0);
  assign rd_data_o = mem_q[rp_q];

endmodule

// File: hdl/cpos_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpos_back
// Pipelined restoring divider, near-point multiply and result queue.
// ----------------------------------------------------------------------------
module cpos_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           issue_i,
  input  cpos_pkg::cls_t cls_i,
  output logic           can_issue_o,
  input  logic           pop_i,
  output logic           empty_o,
  output cpos_pkg::res_t res_o
);
  import cpos_pkg::*;

  logic              v_q   [NS+1];
  logic [PW:0]       rem_q [NS+1];
  logic [FW:0]       quo_q [NS+1];
  cls_t              c_q   [NS+1];

  logic              vm_q;
  logic [FW:0]       fm_q;
  logic signed [MW-1:0] pm_q [3];
  cls_t              cm_q;

  logic [FW+1:0]     frac_sum;
  logic [FW:0]       frac;
  res_t              res_d;
  logic signed [MW:0] rnd;
  logic signed [MW:0] shf;

  res_t              mem_q [OUT_DEPTH];
  logic [OUT_AW-1:0] wp_q, rp_q;
  logic [OUT_CW-1:0] cnt_q, crd_q;
  logic              pop;

  assign pop = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= NS; k++) v_q[k] <= 1'b0;
      vm_q <= 1'b0;
    end else begin
      v_q[0] <= issue_i;
      for (int k = 0; k < NS; k++) v_q[k+1] <= v_q[k];
      vm_q <= v_q[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= {1'b0, cls_i.num};
    quo_q[0] <= '0;
    c_q[0]   <= cls_i;
    for (int k = 0; k < NS; k++) begin
      if ({rem_q[k][PW-1:0], 1'b0} >= {1'b0, c_q[k].den}) begin
        rem_q[k+1] <= {rem_q[k][PW-1:0], 1'b0} - {1'b0, c_q[k].den};
        quo_q[k+1] <= {quo_q[k][FW-1:0], 1'b1};
      end else begin
        rem_q[k+1] <= {rem_q[k][PW-1:0], 1'b0};
        quo_q[k+1] <= {quo_q[k][FW-1:0], 1'b0};
      end
      c_q[k+1] <= c_q[k];
    end
    fm_q <= frac;
    cm_q <= c_q[NS];
    for (int i = 0; i < 3; i++) begin
      pm_q[i] <= MW'($signed(c_q[NS].d[i])) * MW'($signed({1'b0, frac}));
    end
  end

  always_comb begin
    frac_sum = {1'b0, quo_q[NS]} + 1'b1;
    frac     = frac_sum[FW+1:1];
  end

  always_comb begin
    res_d.region = cm_q.region;
    rnd = '0;
    shf = '0;
    case (cm_q.region)
      REG_INSIDE: begin
        res_d.frac = fm_q;
        for (int i = 0; i < 3; i++) begin
          rnd = (MW+1)'(pm_q[i]) + (MW+1)'(1 << (FW - 1));
          shf = rnd >>> FW;
          res_d.near[i] = cm_q.s[i] + shf[CW-1:0];
        end
      end
      REG_BEYOND: begin
        res_d.frac = (FW+1)'(1 << FW);
        res_d.near = cm_q.t;
      end
      default: begin
        res_d.frac = '0;
        res_d.near = cm_q.s;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
      crd_q <= '0;
    end else begin
      if (vm_q) wp_q <= wp_q + 1'b1;
      if (pop)  rp_q <= rp_q + 1'b1;
      if (vm_q && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!vm_q && pop) begin
        cnt_q <= cnt_q - 1'b1;
      end
      if (issue_i && !pop) begin
        crd_q <= crd_q + 1'b1;
      end else if (!issue_i && pop) begin
        crd_q <= crd_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (vm_q) mem_q[wp_q] <= res_d;
  end

  assign can_issue_o = (crd_q < OUT_CW'(OUT_DEPTH));
  assign empty_o     = (cnt_q == '0);
  assign res_o       = mem_q[rp_q];

endmodule

// File: hdl/closest_point_on_segment_3d.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// closest_point_on_segment_3d
// Nearest point on a 3D segment with region and unsigned Q1.16 fraction.
// ----------------------------------------------------------------------------
// Takes one request per clock while full is low. A request passes the front
// (differences, products, sums and classification), then passes an 8-entry
// queue into the back: a 17-stage restoring divider, one multiply stage and a
// 32-entry result queue.
// The front stops taking requests when its queue credit is used up; the back
// stops issuing when its result queue credit is used up.
module closest_point_on_segment_3d (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push,
  output logic                   full,
  input  logic signed [cpos_pkg::CW-1:0] start_x_i,
  input  logic signed [cpos_pkg::CW-1:0] start_y_i,
  input  logic signed [cpos_pkg::CW-1:0] start_z_i,
  input  logic signed [cpos_pkg::CW-1:0] end_x_i,
  input  logic signed [cpos_pkg::CW-1:0] end_y_i,
  input  logic signed [cpos_pkg::CW-1:0] end_z_i,
  input  logic signed [cpos_pkg::CW-1:0] query_x_i,
  input  logic signed [cpos_pkg::CW-1:0] query_y_i,
  input  logic signed [cpos_pkg::CW-1:0] query_z_i,
  output logic                   empty,
  input  logic                   pop,
  output logic [1:0]             region_o,
  output logic [cpos_pkg::FW:0]  fraction_o,
  output logic signed [cpos_pkg::CW-1:0] near_x_o,
  output logic signed [cpos_pkg::CW-1:0] near_y_o,
  output logic signed [cpos_pkg::CW-1:0] near_z_o
);
  import cpos_pkg::*;

  logic accept, cls_valid, mid_empty, can_issue, issue;
  cls_t cls, mid_data;
  res_t res;
  logic [MID_CW-1:0] fcnt_q;

  assign accept = push && !full;
  assign issue  = !mid_empty && can_issue;
  assign full   = (fcnt_q == MID_CW'(MID_DEPTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fcnt_q <= '0;
    end else if (accept && !issue) begin
      fcnt_q <= fcnt_q + 1'b1;
    end else if (!accept && issue) begin
      fcnt_q <= fcnt_q - 1'b1;
    end
  end

  cpos_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (accept),
    .start_i     ({start_z_i, start_y_i, start_x_i}),
    .end_i       ({end_z_i, end_y_i, end_x_i}),
    .query_i     ({query_z_i, query_y_i, query_x_i}),
    .cls_valid_o (cls_valid),
    .cls_o       (cls)
  );

  cpos_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (cls_valid),
    .wr_data_i (cls),
    .rd_i      (issue),
    .empty_o   (mid_empty),
    .rd_data_o (mid_data)
  );

  cpos_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .issue_i     (issue),
    .cls_i       (mid_data),
    .can_issue_o (can_issue),
    .pop_i       (pop),
    .empty_o     (empty),
    .res_o       (res)
  );

  assign region_o   = res.region;
  assign fraction_o = res.frac;
  assign near_x_o   = res.near[0];
  assign near_y_o   = res.near[1];
  assign near_z_o   = res.near[2];

  // queue credit never runs past the queue depth
  a_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fcnt_q <= MID_CW'(MID_DEPTH))
    else $error("front credit overflow");

  a_before: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && region_o == REG_BEFORE) |-> (fraction_o == '0))
    else $error("region before start with nonzero fraction");

  a_beyond: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && region_o == REG_BEYOND) |-> (fraction_o == (FW+1)'(1 << FW)))
    else $error("region beyond end without full fraction");

  a_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |-> (fcnt_q != '0))
    else $error("issue without a queued request");

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 3D segment nearest-point block: a directed table
// of segment extremes and region boundaries, then random requests, each result
// compared against an in-bench fixed-point projection, with random idling except in the last random phase.
// ----------------------------------------------------------------------------
module tb_top;
  import cpos_pkg::*;

  typedef struct {
    logic signed [CW-1:0] c [9];
  } seg_req_t;

  typedef struct {
    region_e              region;
    logic [FW:0]          frac;
    logic signed [CW-1:0] near [3];
  } near_res_t;

  typedef struct {
    seg_req_t  req;
    bit        typed;
    near_res_t res;
  } table_row_t;

  localparam int LIMIT = 400000;
  localparam int N_RAND = 1700;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  logic signed [CW-1:0] coord [9];
  logic [1:0] region_o;
  logic [FW:0] fraction_o;
  logic signed [CW-1:0] near_x_o, near_y_o, near_z_o;

  near_res_t expected_q [$];
  int mismatches = 0;
  int cycles = 0;
  int send_idle = 29;
  int recv_idle = 61;
  bit failed = 1'b0;

  always #2 clk_i = ~clk_i;

  initial begin
    for (int i = 0; i < 9; i++) coord[i] = '0;
  end

  closest_point_on_segment_3d DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full),
    .start_x_i(coord[0]), .start_y_i(coord[1]), .start_z_i(coord[2]),
    .end_x_i(coord[3]), .end_y_i(coord[4]), .end_z_i(coord[5]),
    .query_x_i(coord[6]), .query_y_i(coord[7]), .query_z_i(coord[8]),
    .empty(empty), .pop(pop), .region_o(region_o), .fraction_o(fraction_o),
    .near_x_o(near_x_o), .near_y_o(near_y_o), .near_z_o(near_z_o)
  );

  function automatic near_res_t project_onto_segment(seg_req_t r);
    near_res_t   res;
    longint      dl [3];
    longint      num, den, rem, q, prod;
    num = 0;
    den = 0;
    for (int i = 0; i < 3; i++) begin
      dl[i] = longint'(r.c[3+i]) - longint'(r.c[i]);
      num += dl[i] * (longint'(r.c[6+i]) - longint'(r.c[i]));
      den += dl[i] * dl[i];
    end
    if (den == 0 || num <= 0) begin
      res.region = REG_BEFORE;
      res.frac = '0;
      for (int i = 0; i < 3; i++) res.near[i] = r.c[i];
    end else if (num >= den) begin
      res.region = REG_BEYOND;
      res.frac = (FW+1)'(1 << FW);
      for (int i = 0; i < 3; i++) res.near[i] = r.c[3+i];
    end else begin
      rem = num;
      q = 0;
      for (int i = 0; i <= FW; i++) begin
        rem = rem << 1;
        q = q << 1;
        if (rem >= den) begin
          rem -= den;
          q |= 1;
        end
      end
      q = (q + 1) >>> 1;
      res.region = REG_INSIDE;
      res.frac = q[FW:0];
      for (int i = 0; i < 3; i++) begin
        prod = dl[i] * q + (longint'(1) << (FW - 1));
        res.near[i] = CW'(longint'(r.c[i]) + (prod >>> FW));
      end
    end
    return res;
  endfunction

  function automatic table_row_t row(int sx, int sy, int sz, int tx, int ty, int tz,
                                     int px, int py, int pz, bit typed = 0,
                                     region_e rg = REG_BEFORE, int fr = 0,
                                     int nx = 0, int ny = 0, int nz = 0);
    table_row_t t;
    t.req.c = '{sx, sy, sz, tx, ty, tz, px, py, pz};
    t.typed = typed;
    t.res.region = rg;
    t.res.frac = (FW+1)'(fr);
    t.res.near = '{nx, ny, nz};
    return t;
  endfunction

  function automatic seg_req_t random_req();
    seg_req_t r;
    int span;
    span = $urandom_range(0, 3);
    for (int i = 0; i < 9; i++) begin
      case (span)
        0: r.c[i] = CW'($urandom);
        1: r.c[i] = CW'($urandom_range(0, 40) - 20);
        2: r.c[i] = CW'($urandom_range(0, 4000) - 2000);
        default: r.c[i] = $urandom_range(0, 1) ? 16'sh7fff - $urandom_range(0, 3)
                                                : -16'sh8000 + $urandom_range(0, 3);
      endcase
    end
    // query placed near the segment midpoint in two of three requests, except for the extreme span
    if ($urandom_range(0, 2) != 0 && span != 3) begin
      for (int i = 0; i < 3; i++)
        r.c[6+i] = CW'((longint'(r.c[i]) + longint'(r.c[3+i])) / 2
                       + longint'($urandom_range(0, 6)) - 3);
    end
    if ($urandom_range(0, 30) == 0) for (int i = 0; i < 3; i++) r.c[3+i] = r.c[i];
    return r;
  endfunction

  task automatic send_req(seg_req_t r);
    while ($urandom_range(0, 99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    for (int i = 0; i < 9; i++) coord[i] <= r.c[i];
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    expected_q.push_back(project_onto_segment(r));
  endtask

  task automatic send_typed(table_row_t t);
    near_res_t p;
    p = project_onto_segment(t.req);
    if (t.typed && (p.region != t.res.region || p.frac != t.res.frac ||
                    p.near != t.res.near)) begin
      $display("table row disagrees with predictor");
      failed = 1'b1;
    end
    send_req(t.req);
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni) pop <= ($urandom_range(0, 99) >= recv_idle);
    if (rst_ni && pop && !empty) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with no request waiting");
      end else begin
        near_res_t e;
        e = expected_q.pop_front();
        if (region_o != e.region || fraction_o != e.frac || near_x_o != e.near[0] ||
            near_y_o != e.near[1] || near_z_o != e.near[2]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp r%0d f%0d (%0d %0d %0d) got r%0d f%0d (%0d %0d %0d)",
                     e.region, e.frac, e.near[0], e.near[1], e.near[2], region_o,
                     fraction_o, near_x_o, near_y_o, near_z_o);
        end
      end
    end
    if (cycles > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    table_row_t dir [$];
    dir.push_back(row(0, 0, 0, 0, 0, 0, 5, 5, 5, 1, REG_BEFORE, 0, 0, 0, 0));
    dir.push_back(row(-32768, -32768, -32768, -32768, -32768, -32768, 32767, 32767,
                      32767, 1, REG_BEFORE, 0, -32768, -32768, -32768));
    dir.push_back(row(0, 0, 0, 10, 0, 0, -5, 3, 3, 1, REG_BEFORE, 0, 0, 0, 0));
    dir.push_back(row(0, 0, 0, 10, 0, 0, 0, 7, 0, 1, REG_BEFORE, 0, 0, 0, 0));
    dir.push_back(row(0, 0, 0, 10, 0, 0, 10, -4, 0, 1, REG_BEYOND, 65536, 10, 0, 0));
    dir.push_back(row(0, 0, 0, 10, 0, 0, 30, 0, 9, 1, REG_BEYOND, 65536, 10, 0, 0));
    dir.push_back(row(0, 0, 0, 10, 0, 0, 5, 0, 0, 1, REG_INSIDE, 32768, 5, 0, 0));
    dir.push_back(row(-32768, -32768, -32768, 32767, 32767, 32767, 32767, 32767,
                      32767, 1, REG_BEYOND, 65536, 32767, 32767, 32767));
    dir.push_back(row(-32768, -32768, -32768, 32767, 32767, 32767, -32768, -32768,
                      -32768, 1, REG_BEFORE, 0, -32768, -32768, -32768));
    dir.push_back(row(-32768, -32768, -32768, 32767, 32767, 32767, 0, 0, 0));
    dir.push_back(row(32767, -32768, 32767, -32768, 32767, -32768, 1, -1, 0));
    dir.push_back(row(0, 0, 0, 3, 0, 0, 1, 0, 0));
    dir.push_back(row(0, 0, 0, 1, 1, 1, 1, 1, 0));
    dir.push_back(row(0, 0, 0, -3, 0, 0, -1, 0, 0));
    dir.push_back(row(0, 0, 0, 32767, 0, 0, 1, 0, 0));
    dir.push_back(row(0, 0, 0, 32767, 0, 0, 32766, 0, 0));
    dir.push_back(row(-21846, 21845, -1, 21845, -21846, 0, -1, 0, 32767));
    dir.push_back(row(1, 2, 3, 7, -5, 11, 4, -1, 7));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir[i]) send_typed(dir[i]);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 29 : (phase == 1) ? 61 : 0;
      recv_idle = (phase == 0) ? 61 : (phase == 1) ? 29 : 0;
      for (int n = 0; n < N_RAND / 3; n++) send_req(random_req());
      push <= 1'b0;
      while (expected_q.size() != 0) @(posedge clk_i);
    end

    repeat (40) @(posedge clk_i);
    if (!failed && mismatches == 0 && expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
